@@ hw/rtl/ale_pkg.sv @@
// Package for the associated Laguerre evaluation unit.
// Field widths, fixed-point constants, register indexes and the MAC op struct.
// No dependencies.
package ale_pkg;

	localparam int ARG_W   = 24;
	localparam int VAL_W   = 48;
	localparam int PN_W    = 5;
	localparam int OL_W    = 4;
	localparam int CFG_D_W = 5;
	localparam int CFG_I_W = 1;
	localparam int IDX_W   = 5;
	localparam int COEF_W  = 26;
	localparam int CHUNK_W = 16;
	localparam int MB_W    = CHUNK_W + 1;
	localparam int PROD_W  = COEF_W + MB_W;
	localparam int ACC_W   = 76;
	localparam int NUM_W   = 64;
	localparam int DIVR_W  = 5;
	localparam int BITS_PER_CYC = 8;

	localparam int MAX_PRINCIPAL_DEF = 16;

	localparam logic signed [VAL_W-1:0] ONE_Q16 = 48'sd65536;
	localparam logic signed [NUM_W-1:0] VAL_MAX = 64'sd140737488355327;
	localparam logic signed [NUM_W-1:0] VAL_MIN = -64'sd140737488355328;

	typedef enum logic [CFG_I_W-1:0] {
		CFG_PRINCIPAL = 1'b0,
		CFG_ORBITAL   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic                     valid;
		logic                     clr;
		logic                     sub;
		logic [1:0]               shift;
		logic signed [COEF_W-1:0] a;
		logic signed [MB_W-1:0]   b;
	} mac_op_t;

endpackage

@@ hw/rtl/ale_if.sv @@
// Request and result channel interfaces: valid/ready plus payload.
// Depends on ale_pkg.
interface ale_req_if;
	import ale_pkg::*;
	logic             valid;
	logic             ready;
	logic [ARG_W-1:0] argument;

	modport source (output valid, output argument, input ready);
	modport sink (input valid, input argument, output ready);
endinterface

interface ale_res_if;
	import ale_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] poly_value;
	logic                    saturated;

	modport source (output valid, output poly_value, output saturated, input ready);
	modport sink (input valid, input poly_value, input saturated, output ready);
endinterface

@@ hw/rtl/associated_laguerre_eval_unit.sv @@
// Associated Laguerre evaluator L^k_d(x), k = 2l+1, d = n-l-1, by three-term recurrence.
// Degree 1 or less needs no recurrence step; each step for degree 2 up to 15 runs six
// 26x17 partial products on the shared MAC, then the eight-bit-per-cycle divider.
// One request at a time; ready only while the sequencer idles.
// Reset: principal number 1, orbital number 0, no result pending.
module associated_laguerre_eval_unit #(
	parameter int MAX_PRINCIPAL = ale_pkg::MAX_PRINCIPAL_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [ale_pkg::CFG_I_W-1:0]  wr_index,
	input  logic [ale_pkg::CFG_D_W-1:0]  wr_data,
	ale_req_if.sink                      request,
	ale_res_if.source                    result
);
	import ale_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIVL,
		S_DIVW,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [PN_W-1:0]         pn_q;
	logic [OL_W-1:0]         ol_q;
	logic [2:0]              j_q;
	logic [IDX_W-1:0]        i_q;
	logic [IDX_W-1:0]        d_q;
	logic [5:0]              k_q;
	logic [ARG_W-1:0]        x_q;
	logic signed [VAL_W-1:0] prev1_q;
	logic signed [VAL_W-1:0] prev2_q;
	logic                    sat_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic                    out_sat_q;

	logic [PN_W-1:0]         n_eff;
	logic signed [6:0]       deg;
	logic [5:0]              k_new;
	logic signed [VAL_W-1:0] l1_new;
	logic [6:0]              a_int;
	logic signed [COEF_W-1:0] a_coef;
	logic signed [COEF_W-1:0] c_coef;
	logic signed [VAL_W-1:0] src;
	logic [1:0]              chunk;
	logic [CHUNK_W-1:0]      chunk_bits;
	mac_op_t                 op;
	logic signed [ACC_W-1:0] acc;
	logic                    div_done;
	logic signed [NUM_W-1:0] quot;
	logic signed [NUM_W-1:0] div_num;
	logic signed [VAL_W-1:0] clipped;
	logic                    clip_sat;
	logic                    out_free;

	assign n_eff  = (int'(pn_q) > MAX_PRINCIPAL) ? PN_W'(MAX_PRINCIPAL) : pn_q;
	assign deg    = $signed({2'b0, n_eff}) - $signed({3'b0, ol_q}) - 7'sd1;
	assign k_new  = {1'b0, ol_q, 1'b1};
	assign l1_new = $signed({26'b0, 6'(k_new + 6'd1), 16'b0}) - $signed({24'b0, request.argument});

	assign a_int  = 7'({i_q, 1'b0}) - 7'd1 + {1'b0, k_q};
	assign a_coef = $signed({3'b0, a_int, 16'b0}) - $signed({2'b0, x_q});
	assign c_coef = $signed({20'b0, 6'({1'b0, i_q} - 6'd1 + k_q)});

	assign chunk      = (j_q < 3'd3) ? j_q[1:0] : 2'(j_q - 3'd3);
	assign src        = (j_q < 3'd3) ? prev1_q : prev2_q;
	assign chunk_bits = src[CHUNK_W * chunk +: CHUNK_W];

	always_comb begin
		op.valid = (state_q == S_MUL) && (j_q < 3'd6);
		op.clr   = (state_q == S_MUL) && (j_q == 3'd0);
		op.sub   = (j_q >= 3'd3);
		op.shift = (j_q < 3'd3) ? chunk : 2'(chunk + 2'd1);
		op.a     = (j_q < 3'd3) ? a_coef : c_coef;
		op.b     = (chunk == 2'd2) ? $signed({chunk_bits[CHUNK_W-1], chunk_bits})
		                           : $signed({1'b0, chunk_bits});
	end

	ale_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.acc    (acc)
	);

	assign div_num = NUM_W'($signed(acc[ACC_W-1:16]));

	ale_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_DIVL),
		.num     (div_num),
		.divisor (i_q),
		.done    (div_done),
		.quot    (quot)
	);

	always_comb begin
		clip_sat = 1'b0;
		clipped  = quot[VAL_W-1:0];
		if (quot > VAL_MAX) begin
			clipped  = VAL_MAX[VAL_W-1:0];
			clip_sat = 1'b1;
		end else if (quot < VAL_MIN) begin
			clipped  = VAL_MIN[VAL_W-1:0];
			clip_sat = 1'b1;
		end
	end

	assign out_free      = !out_valid_q || result.ready;
	assign request.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q        <= PN_W'(1);
			ol_q        <= '0;
			state_q     <= S_IDLE;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (cfg_idx_t'(wr_index))
					CFG_PRINCIPAL: pn_q <= wr_data[PN_W-1:0];
					CFG_ORBITAL:   ol_q <= wr_data[OL_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (request.valid) begin
						j_q <= '0;
						if (deg > 7'sd1) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MUL: begin
					j_q <= j_q + 3'd1;
					if (j_q == 3'd6) begin
						state_q <= S_DIVL;
					end
				end
				S_DIVL: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						j_q <= '0;
						if (i_q == d_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && request.valid) begin
			x_q     <= request.argument;
			k_q     <= k_new;
			d_q     <= deg[IDX_W-1:0];
			i_q     <= IDX_W'(2);
			sat_q   <= 1'b0;
			prev2_q <= ONE_Q16;
			if (deg < 7'sd0) begin
				prev1_q <= '0;
			end else if (deg == 7'sd0) begin
				prev1_q <= ONE_Q16;
			end else begin
				prev1_q <= l1_new;
			end
		end else if (state_q == S_DIVW && div_done) begin
			prev2_q <= prev1_q;
			prev1_q <= clipped;
			sat_q   <= sat_q | clip_sat;
			i_q     <= i_q + IDX_W'(1);
		end
		if (state_q == S_DONE && out_free) begin
			out_val_q <= prev1_q;
			out_sat_q <= sat_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.poly_value = out_val_q;
	assign result.saturated  = out_sat_q;
endmodule

@@ hw/rtl/ale_mac.sv @@
// Shared multiply-accumulate unit: 26x17 signed product, registered,
// then shifted by 16-bit chunk position and added to or subtracted from the accumulator.
// Depends on ale_pkg.
module ale_mac (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ale_pkg::mac_op_t               op,
	output logic signed [ale_pkg::ACC_W-1:0] acc
);
	import ale_pkg::*;

	logic                     valid_s1;
	logic                     sub_s1;
	logic [1:0]               shift_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= PROD_W'(op.a * op.b);
		sub_s1   <= op.sub;
		shift_s1 <= op.shift;
	end

	assign term = ACC_W'(prod_s1) <<< (CHUNK_W * int'(shift_s1));

	always_ff @(posedge clk) begin
		if (op.clr) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			if (sub_s1) begin
				acc_q <= acc_q - term;
			end else begin
				acc_q <= acc_q + term;
			end
		end
	end

	assign acc = acc_q;
endmodule

@@ hw/rtl/ale_div.sv @@
// Iterative signed divider by a small unsigned step index, truncating toward zero.
// Eight quotient bits per cycle. Depends on ale_pkg.
module ale_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [ale_pkg::NUM_W-1:0] num,
	input  logic [ale_pkg::DIVR_W-1:0]       divisor,
	output logic                             done,
	output logic signed [ale_pkg::NUM_W-1:0] quot
);
	import ale_pkg::*;

	localparam int ITER   = NUM_W / BITS_PER_CYC;
	localparam int CNT_W  = $clog2(ITER);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [NUM_W-1:0]  mag_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] div_q;
	logic [NUM_W-1:0]  mag_d;
	logic [DIVR_W-1:0] rem_d;

	always_comb begin
		logic [DIVR_W:0] t;
		mag_d = mag_q;
		rem_d = rem_q;
		for (int b = 0; b < BITS_PER_CYC; b++) begin
			t = {rem_d, mag_d[NUM_W-1]};
			if (t >= {1'b0, div_q}) begin
				rem_d = DIVR_W'(t - {1'b0, div_q});
				mag_d = {mag_d[NUM_W-2:0], 1'b1};
			end else begin
				rem_d = t[DIVR_W-1:0];
				mag_d = {mag_d[NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			mag_q <= mag_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule
